### rtl/rfe_pkg.sv
// Shared constants, command/status types and codes for the rational function evaluator.
// Used by every module under rtl/ except rfe_ram.
package rfe_pkg;

   // Number format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits.
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Coefficient store. Slot numbers wrap by dropping high bits (depth is a power of two).
   localparam int MAX_TERMS = 32;
   localparam int ADDR_W    = $clog2(MAX_TERMS);

   // Field and register widths.
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 5;
   localparam int CSR_IDX_W = 2;

   // Datapath widths.
   localparam int PROD_W    = 2 * DATA_WIDTH;
   localparam int SUM_W     = PROD_W + 1;
   localparam int DVD_W     = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // Stream payload widths.
   localparam int REQ_FIELDS_W = IDX_W + 2 * DATA_WIDTH;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;

   // Opcodes carried in req_tuser.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TERMS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_TERMS = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // Source of the final result.
   typedef enum logic [1:0] {
      SEL_NUM  = 2'd0,
      SEL_ZDEN = 2'd1,
      SEL_QUOT = 2'd2
   } sel_type;

   typedef struct packed {
      logic    start;     // latch x, clear accumulator and flag
      logic    mul;       // product <= x * acc
      logic    acc;       // acc <= sat(coef + product >>> FRAC_BITS)
      logic    save_num;  // num <= acc, acc <= 0
      logic    div_init;  // load divider from num and acc
      logic    div_step;  // one restoring division step
      logic    out_load;  // load result register
      sel_type sel;
   } rfe_cmd_type;

   typedef struct packed {
      logic acc_zero;
   } rfe_status_type;

endpackage

### rtl/rfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rfe_datapath.sv
// Datapath: Horner multiply-accumulate, bit-serial divider, result register.
// Depends on rfe_pkg; driven by rfe_ctrl commands.
module rfe_datapath
   import rfe_pkg::*;
(
   input  logic                         clock,
   input  rfe_cmd_type                  cmd,
   input  logic signed [DATA_WIDTH-1:0] x_value,
   input  logic signed [DATA_WIDTH-1:0] coef,
   output rfe_status_type               status,
   output logic signed [DATA_WIDTH-1:0] result_value,
   output logic                         overflow_flag
);

   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [DATA_WIDTH-1:0] num_ff, num_in;
   logic                         ov_ff, ov_in;
   logic [DATA_WIDTH-1:0]        rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]        dvs_ff, dvs_in;
   logic [DVD_W-1:0]             dvd_ff, dvd_in;
   logic                         neg_ff, neg_in;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;
   logic                         res_ov_ff, res_ov_in;

   logic signed [PROD_W-1:0] shifted;
   logic signed [SUM_W-1:0]  sum;
   logic                     sum_ovf;
   logic signed [DATA_WIDTH-1:0] sum_sat;
   logic [DATA_WIDTH:0]      trial;
   logic [DATA_WIDTH:0]      diff;
   logic [DATA_WIDTH-1:0]    num_mag;
   logic [DATA_WIDTH-1:0]    den_mag;
   logic                     q_ovf;
   logic signed [DATA_WIDTH-1:0] q_val;

   localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(1) << (DATA_WIDTH - 1);

   // Horner step: floor shift of the product, add the coefficient, clamp.
   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      sum     = {shifted[PROD_W-1], shifted}
              + {{(SUM_W-DATA_WIDTH){coef[DATA_WIDTH-1]}}, coef};
      sum_ovf = (sum[SUM_W-1:DATA_WIDTH-1] != {(SUM_W-DATA_WIDTH+1){1'b0}})
             && (sum[SUM_W-1:DATA_WIDTH-1] != {(SUM_W-DATA_WIDTH+1){1'b1}});
      if (sum_ovf) begin
         sum_sat = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
         sum_sat = sum[DATA_WIDTH-1:0];
      end
   end

   // Divider step and final quotient clamp.
   always_comb begin
      num_mag = num_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-num_ff) : DATA_WIDTH'(num_ff);
      den_mag = acc_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-acc_ff) : DATA_WIDTH'(acc_ff);
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (neg_ff) begin
         q_ovf = dvd_ff > NEG_LIMIT;
         q_val = q_ovf ? VAL_MIN : DATA_WIDTH'(-dvd_ff[DATA_WIDTH-1:0]);
      end else begin
         q_ovf = dvd_ff[DVD_W-1:DATA_WIDTH-1] != '0;
         q_val = q_ovf ? VAL_MAX : dvd_ff[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      x_in      = x_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      ov_in     = ov_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      dvd_in    = dvd_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      res_ov_in = res_ov_ff;
      if (cmd.start) begin
         x_in   = x_value;
         acc_in = '0;
         ov_in  = 1'b0;
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(x_ff) * PROD_W'(acc_ff);
      end
      if (cmd.acc) begin
         acc_in = sum_sat;
         ov_in  = ov_ff | sum_ovf;
      end
      if (cmd.save_num) begin
         num_in = acc_ff;
         acc_in = '0;
      end
      if (cmd.div_init) begin
         rem_in = '0;
         dvs_in = den_mag;
         dvd_in = {num_mag, {FRAC_BITS{1'b0}}};
         neg_in = num_ff[DATA_WIDTH-1] ^ acc_ff[DATA_WIDTH-1];
      end
      if (cmd.div_step) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         case (cmd.sel)
            SEL_NUM: begin
               res_in    = num_ff;
               res_ov_in = ov_ff;
            end
            SEL_ZDEN: begin
               res_in    = num_ff[DATA_WIDTH-1] ? VAL_MIN : VAL_MAX;
               res_ov_in = 1'b1;
            end
            SEL_QUOT: begin
               res_in    = q_val;
               res_ov_in = ov_ff | q_ovf;
            end
            default: begin
               res_in    = num_ff;
               res_ov_in = ov_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      ov_ff     <= ov_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      dvd_ff    <= dvd_in;
      neg_ff    <= neg_in;
      res_ff    <= res_in;
      res_ov_ff <= res_ov_in;
   end

   assign status.acc_zero = (acc_ff == '0);
   assign result_value    = res_ff;
   assign overflow_flag   = res_ov_ff;

endmodule

### rtl/rfe_ctrl.sv
// Controller FSM: sequences Horner passes, division and result handoff.
// Depends on rfe_pkg; commands rfe_datapath and the coefficient RAM read port.
module rfe_ctrl
   import rfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_opcode,
   output logic              req_tready,
   input  logic [CNT_W-1:0]  num_terms,
   input  logic [CNT_W-1:0]  den_terms,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [ADDR_W-1:0] rd_addr,
   output rfe_cmd_type       cmd,
   input  rfe_status_type    status
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       first_ff, first_in;
   logic                   den_ff, den_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   sel_type                sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W:0]         slot;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

   // Slot of the current term, modulo the store depth.
   assign slot    = {1'b0, first_ff} + {1'b0, k_ff} - (CNT_W+1)'(1);
   assign rd_addr = slot[ADDR_W-1:0];

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      first_in   = first_ff;
      den_in     = den_ff;
      div_cnt_in = div_cnt_ff;
      sel_in     = sel_ff;
      cmd        = '0;
      cmd.sel    = sel_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_opcode == OP_EVAL)) begin
               cmd.start = 1'b1;
               k_in      = num_terms;
               first_in  = '0;
               den_in    = 1'b0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (k_ff != '0) begin
               cmd.mul  = 1'b1;
               state_in = ST_ACC;
            end else if (!den_ff) begin
               cmd.save_num = 1'b1;
               if (den_terms < CNT_W'(2)) begin
                  sel_in   = SEL_NUM;
                  state_in = ST_OUT;
               end else begin
                  den_in   = 1'b1;
                  k_in     = den_terms;
                  first_in = num_terms;
               end
            end else if (status.acc_zero) begin
               sel_in   = SEL_ZDEN;
               state_in = ST_OUT;
            end else begin
               cmd.div_init = 1'b1;
               div_cnt_in   = '0;
               state_in     = ST_DIV;
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            k_in     = k_ff - CNT_W'(1);
            state_in = ST_MUL;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               sel_in   = SEL_QUOT;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff       <= k_in;
      first_ff   <= first_in;
      den_ff     <= den_in;
      div_cnt_ff <= div_cnt_in;
      sel_ff     <= sel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/rational_function_evaluator_unit.sv
// Top level of the rational function evaluator: P(x)/Q(x) in signed Q16.16.
// Depends on rfe_pkg, rfe_ram, rfe_ctrl and rfe_datapath.
//
// Usage:
//  - req channel: one transaction is a load (req_tuser = 0) that writes one coefficient
//    slot, or an evaluate (req_tuser = 1) at x. Numerator coefficients sit in slots
//    0 .. N-1, denominator coefficients in N .. N+D-1, constant term first.
//  - rsp channel: one transaction per evaluate, none per load. rsp_tuser flags
//    saturation anywhere in the computation or a zero denominator.
//  - csr port: numerator_terms (N) and denominator_terms (D); write only while idle.
//    D below 2 returns the numerator polynomial alone.
//  - Load: the unit stays idle, so the next transaction can follow immediately.
//  - Evaluate: each Horner term runs through ST_MUL (registered RAM read plus
//    multiply), then ST_ACC (add/clamp). A rational evaluate then runs a 48-step
//    restoring divider, one quotient bit a cycle; a zero denominator skips it.
//  - Only one evaluate is in flight. A finished result waits in the output register
//    while rsp_tready is low; a new request is still taken, and its own result is
//    held back until the previous one has gone.
//  - Reset (synchronous) idles the sequencer, drops rsp_tvalid and restores N = 1,
//    D = 0. Coefficient slots are not cleared; load them before use.
module rational_function_evaluator_unit
   import rfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [4:0] coef_index, [36:5] coef_value, [68:37] x_value, [71:69] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                   req_tuser,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] result_value
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] overflow_flag
   output logic                   rsp_tuser,
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CNT_W-1:0]       csr_wdata
);

   logic [IDX_W-1:0]             req_coef_index;
   logic signed [DATA_WIDTH-1:0] req_coef_value;
   logic signed [DATA_WIDTH-1:0] req_x_value;

   logic [CNT_W-1:0] num_terms_ff, num_terms_in;
   logic [CNT_W-1:0] den_terms_ff, den_terms_in;

   logic                         coef_we;
   logic [ADDR_W-1:0]            rd_addr;
   logic signed [DATA_WIDTH-1:0] coef_rdata;
   rfe_cmd_type                  cmd;
   rfe_status_type               status;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         overflow_flag;

   // Request unpacking.
   assign req_coef_index = req_tdata[IDX_W-1:0];
   assign req_coef_value = req_tdata[IDX_W+DATA_WIDTH-1:IDX_W];
   assign req_x_value    = req_tdata[IDX_W+2*DATA_WIDTH-1:IDX_W+DATA_WIDTH];

   // Configuration registers; unknown indexes are dropped.
   always_comb begin
      num_terms_in = num_terms_ff;
      den_terms_in = den_terms_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_TERMS: num_terms_in = csr_wdata;
            CSR_DEN_TERMS: den_terms_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= CNT_W'(1);
         den_terms_ff <= '0;
      end else begin
         num_terms_ff <= num_terms_in;
         den_terms_ff <= den_terms_in;
      end
   end

   // Loads go straight into the store; a slot past the store is ignored.
   assign coef_we = req_tvalid && req_tready && (req_tuser == OP_LOAD)
                 && (32'(req_coef_index) < MAX_TERMS);

   rfe_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_TERMS)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (req_coef_index[ADDR_W-1:0]),
      .wdata (req_coef_value),
      .raddr (rd_addr),
      .rdata (coef_rdata)
   );

   rfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .num_terms  (num_terms_ff),
      .den_terms  (den_terms_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rd_addr    (rd_addr),
      .cmd        (cmd),
      .status     (status)
   );

   rfe_datapath u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .x_value       (req_x_value),
      .coef          (coef_rdata),
      .status        (status),
      .result_value  (result_value),
      .overflow_flag (overflow_flag)
   );

   assign rsp_tdata = RSP_TDATA_W'(result_value);
   assign rsp_tuser = overflow_flag;

endmodule

### rtl/rfe_checker.sv
// Port-level checks for rational_function_evaluator_unit, attached by bind.
// Depends on rfe_pkg.
module rfe_checker
   import rfe_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // Stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // No response right out of reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // A load never produces a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after load transaction");

   // An evaluate occupies the unit.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_EVAL) |=> !req_tready)
      else $error("request taken during evaluation");

   // A new response only appears at the end of an evaluation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without evaluation");

endmodule

bind rational_function_evaluator_unit rfe_checker u_rfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
